// ===== rtl/pbrq_pkg.sv =====
// Shared codes, state type and default sizes of the priority bucket ready queue.
package pbrq_pkg;

    // Default sizes
    localparam int DEF_NUM_LEVELS  = 64;
    localparam int DEF_NUM_HANDLES = 64;

    // Levels per group in the top-level finder
    localparam int FIND_GROUP = 16;

    // Field widths on the streams
    localparam int ACT_W  = 2;
    localparam int ID_W   = 6;
    localparam int PRI_W  = 6;
    localparam int STAT_W = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ALREADY_IN = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_QUEUED = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_A,
        S_PUSH_B,
        S_POP_RD,
        S_POP_A,
        S_REM_RD,
        S_REM_A,
        S_UNLINK,
        S_MID1,
        S_MID2,
        S_FIND1,
        S_FIND2,
        S_DONE
    } state_t;

endpackage

// ===== rtl/priority_bucket_ready_queue.sv =====
// Top level of the priority bucket ready queue: sequencer, link memories and result register.
// Input words are taken one at a time: a new word is accepted only once the result of the
// last one is loaded into the result register. Each word is worked in read-modify-write
// steps on the single write port of the handle memory and the two-stage top-level finder.
// Reset: a clearing pass zeroes every handle memory entry with s_axis_tready low; head and
// tail entries stay undefined until written and the level map resets empty.
module priority_bucket_ready_queue
    import pbrq_pkg::*;
#(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int NUM_HANDLES = DEF_NUM_HANDLES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // element_id[5:0], priority_req[11:6], zero fill
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // popped_id[5:0], popped_priority[11:6],
                                       // queue_empty[12], top_level[18:13], zero fill
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int LW    = $clog2(NUM_LEVELS);
    localparam int HW    = $clog2(NUM_HANDLES);
    localparam int MAXLV = NUM_LEVELS - 1;

    typedef struct packed {
        logic          queued;
        logic [LW-1:0] level;
        logic [HW-1:0] prev;
        logic [HW-1:0] next;
    } hrec_t;

    typedef struct packed {
        logic [HW-1:0] head;
        logic [HW-1:0] tail;
    } lrec_t;

    // Memories
    hrec_t h_mem [NUM_HANDLES];
    lrec_t l_mem [NUM_LEVELS];

    hrec_t         h_rd_a_reg;
    hrec_t         h_rd_b_reg;
    lrec_t         l_rd_reg;
    logic          h_re_a;
    logic          h_re_b;
    logic [HW-1:0] h_raddr_a;
    logic [HW-1:0] h_raddr_b;
    logic          h_we;
    logic [HW-1:0] h_waddr;
    hrec_t         h_wdata;
    logic          l_re;
    logic [LW-1:0] l_raddr;
    logic          l_we;
    logic [LW-1:0] l_waddr;
    lrec_t         l_wdata;

    // Control state
    state_t                state_reg;
    state_t                state_next;
    logic [NUM_LEVELS-1:0] map_reg;
    logic                  map_set;
    logic                  map_clr;
    logic [HW-1:0]         clr_cnt_reg;
    logic [HW-1:0]         clr_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // Working registers
    logic [HW-1:0]     cur_h_reg;
    logic [HW-1:0]     cur_h_next;
    logic [LW-1:0]     cur_lv_reg;
    logic [LW-1:0]     cur_lv_next;
    logic [STAT_W-1:0] stat_reg;
    logic [STAT_W-1:0] stat_next;
    logic [HW-1:0]     pid_reg;
    logic [HW-1:0]     pid_next;
    logic [LW-1:0]     ppri_reg;
    logic [LW-1:0]     ppri_next;
    logic [HW-1:0]     sv_next_reg;
    logic [HW-1:0]     sv_next_next;
    logic [HW-1:0]     sv_prev_reg;
    logic [HW-1:0]     sv_prev_next;

    // Result register
    logic [STAT_W-1:0] out_stat_reg;
    logic [ID_W-1:0]   out_pid_reg;
    logic [PRI_W-1:0]  out_ppri_reg;
    logic              out_empty_reg;
    logic [PRI_W-1:0]  out_top_reg;

    // Input decode
    logic [ACT_W-1:0] in_action;
    logic [ID_W-1:0]  in_id;
    logic [PRI_W-1:0] in_pri;
    logic [HW-1:0]    in_h;
    logic [LW-1:0]    in_lv;
    logic             s_fire;
    logic             out_load;

    // Finder outputs
    logic          top_found;
    logic [LW-1:0] top_lv;

    // Decode of memory data
    logic at_head;
    logic at_tail;
    logic lv_busy;

    assign in_action = s_axis_tuser;
    assign in_id     = s_axis_tdata[5:0];
    assign in_pri    = s_axis_tdata[11:6];

    // Wrap the handle through a constant table
    always_comb
    begin
        in_h = '0;
        for (int i = 0; i < (1 << ID_W); i++)
        begin
            if (in_id == ID_W'(i))
            begin
                in_h = HW'(i % NUM_HANDLES);
            end
        end
    end

    // Saturate the level
    assign in_lv = (int'(in_pri) > MAXLV) ? LW'(MAXLV) : LW'(in_pri);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_load      = !out_valid_reg || m_axis_tready;

    assign at_head = (l_rd_reg.head == cur_h_reg);
    assign at_tail = (l_rd_reg.tail == cur_h_reg);
    assign lv_busy = map_reg[cur_lv_reg];

    pbrq_top_find #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_find (
        .clk       (clk),
        .rst_n     (rst_n),
        .level_map (map_reg),
        .found     (top_found),
        .top       (top_lv)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_cnt_reg == HW'(NUM_HANDLES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_fire)
                begin
                    case (in_action)
                        ACT_PUSH:   state_next = S_PUSH_RD;
                        ACT_POP:    state_next = S_POP_RD;
                        ACT_REMOVE: state_next = S_REM_RD;
                        default:    state_next = S_FIND1;
                    endcase
                end
            end
            S_PUSH_RD: state_next = S_PUSH_A;
            S_PUSH_A:
            begin
                if (!h_rd_a_reg.queued && lv_busy)
                begin
                    state_next = S_PUSH_B;
                end
                else
                begin
                    state_next = S_FIND1;
                end
            end
            S_PUSH_B: state_next = S_FIND1;
            S_POP_RD: state_next = top_found ? S_POP_A : S_FIND1;
            S_POP_A:  state_next = S_UNLINK;
            S_REM_RD: state_next = S_REM_A;
            S_REM_A:  state_next = h_rd_a_reg.queued ? S_UNLINK : S_FIND1;
            S_UNLINK: state_next = (!at_head && !at_tail) ? S_MID1 : S_FIND1;
            S_MID1:   state_next = S_MID2;
            S_MID2:   state_next = S_FIND1;
            S_FIND1:  state_next = S_FIND2;
            S_FIND2:  state_next = S_DONE;
            S_DONE:   state_next = out_load ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Memory controls and working register updates
    always_comb
    begin
        h_re_a       = 1'b0;
        h_re_b       = 1'b0;
        h_raddr_a    = cur_h_reg;
        h_raddr_b    = h_rd_a_reg.next;
        h_we         = 1'b0;
        h_waddr      = cur_h_reg;
        h_wdata      = h_rd_a_reg;
        l_re         = 1'b0;
        l_raddr      = cur_lv_reg;
        l_we         = 1'b0;
        l_waddr      = cur_lv_reg;
        l_wdata      = l_rd_reg;
        map_set      = 1'b0;
        map_clr      = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        cur_h_next   = cur_h_reg;
        cur_lv_next  = cur_lv_reg;
        stat_next    = stat_reg;
        pid_next     = pid_reg;
        ppri_next    = ppri_reg;
        sv_next_next = sv_next_reg;
        sv_prev_next = sv_prev_reg;
        case (state_reg)
            S_CLR:
            begin
                // Zero one handle entry a cycle
                h_we         = 1'b1;
                h_waddr      = clr_cnt_reg;
                h_wdata      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (s_fire)
                begin
                    cur_h_next  = in_h;
                    cur_lv_next = in_lv;
                    stat_next   = ST_OK;
                    pid_next    = '0;
                    ppri_next   = '0;
                end
            end
            S_PUSH_RD:
            begin
                h_re_a = 1'b1;
                l_re   = 1'b1;
            end
            S_PUSH_A:
            begin
                if (h_rd_a_reg.queued)
                begin
                    stat_next = ST_ALREADY_IN;
                end
                else if (lv_busy)
                begin
                    // Append behind the current tail
                    l_we         = 1'b1;
                    l_wdata.head = l_rd_reg.head;
                    l_wdata.tail = cur_h_reg;
                    h_we         = 1'b1;
                    h_wdata      = hrec_t'{queued: 1'b1, level: cur_lv_reg,
                                           prev: l_rd_reg.tail, next: h_rd_a_reg.next};
                    h_re_b       = 1'b1;
                    h_raddr_b    = l_rd_reg.tail;
                end
                else
                begin
                    // Start a new level
                    l_we         = 1'b1;
                    l_wdata.head = cur_h_reg;
                    l_wdata.tail = cur_h_reg;
                    map_set      = 1'b1;
                    h_we         = 1'b1;
                    h_wdata      = hrec_t'{queued: 1'b1, level: cur_lv_reg,
                                           prev: h_rd_a_reg.prev, next: h_rd_a_reg.next};
                end
            end
            S_PUSH_B:
            begin
                // Link old tail forward to the new handle
                h_we         = 1'b1;
                h_waddr      = l_rd_reg.tail;
                h_wdata      = h_rd_b_reg;
                h_wdata.next = cur_h_reg;
            end
            S_POP_RD:
            begin
                if (!top_found)
                begin
                    stat_next = ST_POP_EMPTY;
                end
                else
                begin
                    l_re        = 1'b1;
                    l_raddr     = top_lv;
                    cur_lv_next = top_lv;
                    ppri_next   = top_lv;
                end
            end
            S_POP_A:
            begin
                h_re_a     = 1'b1;
                h_raddr_a  = l_rd_reg.head;
                cur_h_next = l_rd_reg.head;
                pid_next   = l_rd_reg.head;
            end
            S_REM_RD:
            begin
                h_re_a = 1'b1;
            end
            S_REM_A:
            begin
                if (!h_rd_a_reg.queued)
                begin
                    stat_next = ST_NOT_QUEUED;
                end
                else
                begin
                    l_re        = 1'b1;
                    l_raddr     = h_rd_a_reg.level;
                    cur_lv_next = h_rd_a_reg.level;
                end
            end
            S_UNLINK:
            begin
                // Drop the queued mark and fix head, tail or neighbors
                h_we           = 1'b1;
                h_wdata.queued = 1'b0;
                sv_next_next   = h_rd_a_reg.next;
                sv_prev_next   = h_rd_a_reg.prev;
                if (at_head && at_tail)
                begin
                    map_clr = 1'b1;
                end
                else if (at_head)
                begin
                    l_we         = 1'b1;
                    l_wdata.head = h_rd_a_reg.next;
                end
                else if (at_tail)
                begin
                    l_we         = 1'b1;
                    l_wdata.tail = h_rd_a_reg.prev;
                end
                else
                begin
                    h_re_a    = 1'b1;
                    h_raddr_a = h_rd_a_reg.prev;
                    h_re_b    = 1'b1;
                    h_raddr_b = h_rd_a_reg.next;
                end
            end
            S_MID1:
            begin
                h_we         = 1'b1;
                h_waddr      = sv_prev_reg;
                h_wdata      = h_rd_a_reg;
                h_wdata.next = sv_next_reg;
            end
            S_MID2:
            begin
                h_we         = 1'b1;
                h_waddr      = sv_next_reg;
                h_wdata      = h_rd_b_reg;
                h_wdata.prev = sv_prev_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == S_DONE && out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            h_mem[h_waddr] <= h_wdata;
        end
        if (h_re_a)
        begin
            h_rd_a_reg <= h_mem[h_raddr_a];
        end
        if (h_re_b)
        begin
            h_rd_b_reg <= h_mem[h_raddr_b];
        end
        if (l_we)
        begin
            l_mem[l_waddr] <= l_wdata;
        end
        if (l_re)
        begin
            l_rd_reg <= l_mem[l_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            map_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (map_set)
            begin
                map_reg[cur_lv_reg] <= 1'b1;
            end
            else if (map_clr)
            begin
                map_reg[cur_lv_reg] <= 1'b0;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        cur_h_reg   <= cur_h_next;
        cur_lv_reg  <= cur_lv_next;
        stat_reg    <= stat_next;
        pid_reg     <= pid_next;
        ppri_reg    <= ppri_next;
        sv_next_reg <= sv_next_next;
        sv_prev_reg <= sv_prev_next;
        if (state_reg == S_DONE && out_load)
        begin
            out_stat_reg  <= stat_reg;
            out_pid_reg   <= ID_W'(pid_reg);
            out_ppri_reg  <= PRI_W'(ppri_reg);
            out_empty_reg <= !top_found;
            out_top_reg   <= PRI_W'(top_lv);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_stat_reg;
    assign m_axis_tdata  = {5'd0, out_top_reg, out_empty_reg, out_ppri_reg, out_pid_reg};

    // Same-cycle read and write never touch one handle entry
    a_h_port_a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (h_we && h_re_a) |-> (h_waddr != h_raddr_a))
        else $error("handle memory read A and write hit the same entry");

    a_h_port_b_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (h_we && h_re_b) |-> (h_waddr != h_raddr_b))
        else $error("handle memory read B and write hit the same entry");

    // A level is opened only when empty and closed only when busy
    a_map_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (map_set |-> !map_reg[cur_lv_reg]) and (map_clr |-> map_reg[cur_lv_reg]))
        else $error("level map set or clear on a level in the wrong state");

    // One item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("input taken again before the item finished");

endmodule

// ===== rtl/pbrq_top_find.sv =====
// Two-stage registered search for the highest non-empty priority level.
module pbrq_top_find
    import pbrq_pkg::*;
#(
    parameter int NUM_LEVELS = DEF_NUM_LEVELS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [NUM_LEVELS-1:0]         level_map,
    output logic                          found,
    output logic [$clog2(NUM_LEVELS)-1:0] top
);

    localparam int LW  = $clog2(NUM_LEVELS);
    localparam int NG  = (NUM_LEVELS + FIND_GROUP - 1) / FIND_GROUP;
    localparam int GIW = $clog2(FIND_GROUP);
    localparam int PW  = NG * FIND_GROUP;

    logic [PW-1:0]  map_pad;
    logic [NG-1:0]  grp_any_reg;
    logic [NG-1:0]  grp_any_next;
    logic [GIW-1:0] grp_idx_reg  [NG];
    logic [GIW-1:0] grp_idx_next [NG];
    logic           found_reg;
    logic           found_next;
    logic [LW-1:0]  top_reg;
    logic [LW-1:0]  top_next;

    assign map_pad = PW'(level_map);

    // Stage one: highest set bit inside each group
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = |map_pad[g*FIND_GROUP +: FIND_GROUP];
            grp_idx_next[g] = '0;
            for (int j = 0; j < FIND_GROUP; j++)
            begin
                if (map_pad[g*FIND_GROUP + j])
                begin
                    grp_idx_next[g] = GIW'(j);
                end
            end
        end
    end

    // Stage two: highest non-empty group
    always_comb
    begin
        found_next = 1'b0;
        top_next   = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (grp_any_reg[g])
            begin
                found_next = 1'b1;
                top_next   = LW'(g * FIND_GROUP + int'(grp_idx_reg[g]));
            end
        end
    end

    // Hold both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_any_reg <= '0;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= '0;
            end
            found_reg <= 1'b0;
            top_reg   <= '0;
        end
        else
        begin
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
            found_reg <= found_next;
            top_reg   <= top_next;
        end
    end

    assign found = found_reg;
    assign top   = top_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the priority bucket ready queue: mirrored list state, random traffic.
`timescale 1ns / 100ps

module tb_top;
    import pbrq_pkg::*;

    // Action code the block leaves without effect
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    // Per-phase random word counts
    localparam int PHASE_WORDS = 517;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   popped_id;
        logic [PRI_W-1:0]  popped_level;
        logic              now_empty;
        logic [PRI_W-1:0]  top_level;
    } queue_result_t;

    // Mirror of the link tables plus the list of results still owed by the block
    class ready_queue_scoreboard;
        logic [ID_W-1:0]  lvl_head [DEF_NUM_LEVELS];
        logic [ID_W-1:0]  lvl_tail [DEF_NUM_LEVELS];
        logic [ID_W-1:0]  next_hdl [DEF_NUM_HANDLES];
        logic [ID_W-1:0]  prev_hdl [DEF_NUM_HANDLES];
        logic [PRI_W-1:0] hdl_level [DEF_NUM_HANDLES];
        bit               in_queue [DEF_NUM_HANDLES];
        logic [DEF_NUM_LEVELS-1:0] busy_map;
        queue_result_t    owed_results [$];
        int               occupancy;
        int               peak_occupancy;
        int               errors;
        int               checked;
        int               status_seen [4];

        function new();
            foreach (lvl_head[i])
            begin
                lvl_head[i] = '0;
                lvl_tail[i] = '0;
            end
            foreach (next_hdl[i])
            begin
                next_hdl[i]  = '0;
                prev_hdl[i]  = '0;
                hdl_level[i] = '0;
                in_queue[i]  = 0;
            end
            busy_map = '0;
            occupancy = 0;
            peak_occupancy = 0;
            errors = 0;
            checked = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function logic [PRI_W-1:0] top_busy_level();
            for (int lv = DEF_NUM_LEVELS - 1; lv >= 0; lv--)
                if (busy_map[lv])
                    return PRI_W'(lv);
            return '0;
        endfunction

        // Take a handle out of the list of its level
        function void unlink_handle(logic [ID_W-1:0] h);
            logic [PRI_W-1:0] lv;
            bit at_head;
            bit at_tail;
            lv = hdl_level[h];
            at_head = (lvl_head[lv] == h);
            at_tail = (lvl_tail[lv] == h);
            if (at_head && at_tail)
                busy_map[lv] = 1'b0;
            else if (at_head)
                lvl_head[lv] = next_hdl[h];
            else if (at_tail)
                lvl_tail[lv] = prev_hdl[h];
            else
            begin
                next_hdl[prev_hdl[h]] = next_hdl[h];
                prev_hdl[next_hdl[h]] = prev_hdl[h];
            end
            in_queue[h] = 0;
            occupancy--;
        endfunction

        // Apply one accepted word to the mirror and queue up its result
        function void predict_queue_op(logic [ACT_W-1:0] act, logic [ID_W-1:0] h,
                                       logic [PRI_W-1:0] lv);
            queue_result_t res;
            logic [PRI_W-1:0] top;
            logic [ID_W-1:0] t;
            res = '0;
            res.status = ST_OK;
            if (act == ACT_PUSH)
            begin
                if (in_queue[h])
                    res.status = ST_ALREADY_IN;
                else
                begin
                    if (busy_map[lv])
                    begin
                        t = lvl_tail[lv];
                        next_hdl[t] = h;
                        prev_hdl[h] = t;
                        lvl_tail[lv] = h;
                    end
                    else
                    begin
                        lvl_head[lv] = h;
                        lvl_tail[lv] = h;
                        busy_map[lv] = 1'b1;
                    end
                    hdl_level[h] = lv;
                    in_queue[h] = 1;
                    occupancy++;
                    if (occupancy > peak_occupancy)
                        peak_occupancy = occupancy;
                end
            end
            else if (act == ACT_POP)
            begin
                if (busy_map == '0)
                    res.status = ST_POP_EMPTY;
                else
                begin
                    top = top_busy_level();
                    res.popped_id = lvl_head[top];
                    res.popped_level = top;
                    unlink_handle(lvl_head[top]);
                end
            end
            else if (act == ACT_REMOVE)
            begin
                if (!in_queue[h])
                    res.status = ST_NOT_QUEUED;
                else
                    unlink_handle(h);
            end
            res.now_empty = (busy_map == '0);
            res.top_level = top_busy_level();
            owed_results.push_back(res);
        endfunction

        // Compare one delivered result against the oldest owed one
        function void check_result(queue_result_t got);
            queue_result_t want;
            if (owed_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result word %h", $realtime, got);
                return;
            end
            want = owed_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status != want.status || got.popped_id != want.popped_id ||
                got.popped_level != want.popped_level || got.now_empty != want.now_empty ||
                got.top_level != want.top_level)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch on result %0d: status %0d/%0d id %0d/%0d lvl %0d/%0d empty %0d/%0d top %0d/%0d (exp/act)",
                             $realtime, checked, want.status, got.status,
                             want.popped_id, got.popped_id, want.popped_level,
                             got.popped_level, want.now_empty, got.now_empty,
                             want.top_level, got.top_level);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [23:0]         m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    ready_queue_scoreboard sb;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  hold_off_req;

    priority_bucket_ready_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one word, idling first at random, and record it once accepted
    task automatic send_word(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                             logic [PRI_W-1:0] lv);
        bit offered;
        offered = 0;
        while (!offered)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < send_idle_pct)
                s_axis_tvalid = 1'b0;
            else
            begin
                s_axis_tdata  = {4'b0, lv, id};
                s_axis_tuser  = act;
                s_axis_tvalid = 1'b1;
                offered = 1;
            end
        end
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.predict_queue_op(act, id, lv);
    endtask

    // Favor a few shared levels so lists grow long
    function automatic logic [PRI_W-1:0] random_level();
        if ($urandom_range(0, 1))
            return PRI_W'($urandom_range(0, DEF_NUM_LEVELS - 1));
        return PRI_W'($urandom_range(0, 3) * 21);
    endfunction

    // Find a handle with the wanted queued state, scanning from a random start
    function automatic int pick_handle(bit queued);
        int start;
        int h;
        start = $urandom_range(0, DEF_NUM_HANDLES - 1);
        for (int k = 0; k < DEF_NUM_HANDLES; k++)
        begin
            h = (start + k) % DEF_NUM_HANDLES;
            if (sb.in_queue[h] == queued)
                return h;
        end
        return -1;
    endfunction

    // Mostly legal traffic, with duplicates, stray removes and spare codes as noise
    task automatic send_random_word(output logic [ACT_W-1:0] act);
        int roll;
        int h;
        logic [ID_W-1:0] id;
        id = ID_W'($urandom_range(0, DEF_NUM_HANDLES - 1));
        roll = $urandom_range(0, 99);
        act = ACT_POP;
        if (roll < 85)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ((sb.occupancy < 16) ? 55 : 35))
            begin
                h = pick_handle(0);
                if (h >= 0)
                begin
                    act = ACT_PUSH;
                    id = ID_W'(h);
                end
            end
            else if (roll >= 70)
            begin
                h = pick_handle(1);
                if (h >= 0)
                begin
                    act = ACT_REMOVE;
                    id = ID_W'(h);
                end
            end
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    act = ACT_PUSH;
                    h = pick_handle(1);
                    if (h >= 0)
                        id = ID_W'(h);
                end
                1:
                begin
                    act = ACT_REMOVE;
                    h = pick_handle(0);
                    if (h >= 0)
                        id = ID_W'(h);
                end
                2:
                    act = ACT_SPARE;
                default:
                    act = ACT_POP;
            endcase
        end
        send_word(act, id, random_level());
    endtask

    task automatic run_random_phase(int words);
        int n;
        logic [ACT_W-1:0] act;
        n = 0;
        while (n < words)
        begin
            send_random_word(act);
            if (act != ACT_SPARE)
                n++;
        end
    endtask

    // Result side: random backpressure, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 0;
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every delivered word
    initial
    begin
        queue_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.status       = m_axis_tuser;
                got.popped_id    = m_axis_tdata[5:0];
                got.popped_level = m_axis_tdata[11:6];
                got.now_empty    = m_axis_tdata[12];
                got.top_level    = m_axis_tdata[18:13];
                sb.check_result(got);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("Timeout with %0d results still owed", sb.owed_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_PUSH;
        hold_off_req = 0;
        send_idle_pct = 20;
        recv_idle_pct = 68;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty queue rejects, extremes, one level's list worked from all ends
        send_word(ACT_POP, 6'd0, 6'd0);
        send_word(ACT_REMOVE, 6'd5, 6'd0);
        send_word(ACT_SPARE, 6'd63, 6'd63);
        send_word(ACT_PUSH, 6'd0, 6'd0);
        send_word(ACT_PUSH, 6'd63, 6'd63);
        send_word(ACT_PUSH, 6'd63, 6'd10);
        send_word(ACT_PUSH, 6'd1, 6'd40);
        send_word(ACT_PUSH, 6'd2, 6'd40);
        send_word(ACT_PUSH, 6'd3, 6'd40);
        send_word(ACT_PUSH, 6'd4, 6'd40);
        send_word(ACT_REMOVE, 6'd2, 6'd0);
        send_word(ACT_REMOVE, 6'd1, 6'd0);
        send_word(ACT_REMOVE, 6'd4, 6'd0);
        send_word(ACT_REMOVE, 6'd3, 6'd0);
        send_word(ACT_POP, 6'd0, 6'd0);
        send_word(ACT_PUSH, 6'd42, 6'd21);
        send_word(ACT_PUSH, 6'd21, 6'd42);
        send_word(ACT_POP, 6'd0, 6'd0);
        send_word(ACT_POP, 6'd0, 6'd0);
        send_word(ACT_POP, 6'd0, 6'd0);
        send_word(ACT_POP, 6'd0, 6'd0);
        send_word(ACT_REMOVE, 6'd0, 6'd0);

        run_random_phase(PHASE_WORDS);
        send_idle_pct = 68;
        recv_idle_pct = 20;
        run_random_phase(PHASE_WORDS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1;
        run_random_phase(PHASE_WORDS);
        @(negedge clk);
        s_axis_tvalid = 1'b0;

        // Drain, then watch for stray results
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.owed_results.size() != 0)
            sb.errors++;

        $display("Checked %0d results: %0d ok, %0d pops on empty, %0d duplicate pushes, %0d stray removes",
                 sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_POP_EMPTY],
                 sb.status_seen[ST_ALREADY_IN], sb.status_seen[ST_NOT_QUEUED]);
        $display("Peak of %0d handles queued, %0d failures", sb.peak_occupancy, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
